// ===== hw/rtl/dhsd_pkg.sv =====
// Shared constants, types and helper functions for the DNA string dictionary.
`default_nettype none

package dhsd_pkg;

  // Number of slots in the key table.
  localparam int TABLE_SIZE = 4093;

  // Field widths of the request and result transactions.
  localparam int OP_W         = 1;
  localparam int LETTERS_W    = 24;
  localparam int LEN_W        = 4;
  localparam int STATUS_W     = 3;
  localparam int SLOT_FIELD_W = 12;

  // Key and slot widths.
  localparam int KEY_W       = 28;
  localparam int MAX_LETTERS = 12;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W       = $clog2(TABLE_SIZE + 1);

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_FIND   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Table size and the size less one as key-wide constants.
  localparam logic [KEY_W-1:0] MOD_POS  = KEY_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] MOD_STEP = KEY_W'(TABLE_SIZE - 1);

  // Reciprocals scaled by 2^KEY_W; the quotient estimate is at most one low.
  localparam logic [KEY_W-1:0] RECIP_POS  = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);
  localparam logic [KEY_W-1:0] RECIP_STEP = KEY_W'((64'd1 << KEY_W) / (TABLE_SIZE - 1));

  // Base-5 weight of each letter position.
  localparam logic [KEY_W-1:0] LETTER_WEIGHT [MAX_LETTERS] = '{
    28'd1, 28'd5, 28'd25, 28'd125, 28'd625, 28'd3125, 28'd15625,
    28'd78125, 28'd390625, 28'd1953125, 28'd9765625, 28'd48828125
  };

  // One hashed request as it travels from the front to the back end.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] step;
  } job_t;

  // Modular add of a slot and a step, both below the table size.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (SLOT_W + 1)'(TABLE_SIZE)) begin
      sum = sum - (SLOT_W + 1)'(TABLE_SIZE);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Low bits of a slot number as carried in the result field.
  function automatic logic [SLOT_FIELD_W-1:0] to_slot_field(input logic [SLOT_W-1:0] pos);
    logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
    wide = {{SLOT_FIELD_W{1'b0}}, pos};
    return wide[SLOT_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dhsd_in_if.sv =====
// Request channel: valid/ready handshake with operation, letters and length.
`default_nettype none

interface dhsd_in_if;
  logic                             valid;
  logic                             ready;
  logic [dhsd_pkg::OP_W-1:0]        operation;
  logic [dhsd_pkg::LETTERS_W-1:0]   letters;
  logic [dhsd_pkg::LEN_W-1:0]       length;

  modport source (output valid, output operation, output letters, output length,
                  input ready);
  modport sink   (input valid, input operation, input letters, input length,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dhsd_out_if.sv =====
// Result channel: valid/ready handshake with status and slot.
`default_nettype none

interface dhsd_out_if;
  logic                                valid;
  logic                                ready;
  logic [dhsd_pkg::STATUS_W-1:0]       status;
  logic [dhsd_pkg::SLOT_FIELD_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dhsd_front.sv =====
// Front end: forms the base-5 key and both hash values in a three-stage pipeline.
`default_nettype none

module dhsd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  dhsd_in_if.sink           in_ch,
  output dhsd_pkg::job_t    job,
  output logic              job_valid,
  input  wire logic         job_ready
);

  localparam int KW = dhsd_pkg::KEY_W;
  localparam int SW = dhsd_pkg::SLOT_W;

  logic                       s1_valid_r, s2_valid_r, s3_valid_r;
  logic                       ready1, ready2, ready3;
  logic [dhsd_pkg::OP_W-1:0]  s1_op_r, s2_op_r, s3_op_r;
  logic [KW-1:0]              s1_key_r, s2_key_r, s3_key_r;
  logic [KW-1:0]              s2_qpos_r, s2_qstep_r;
  logic [SW-1:0]              s3_pos_r, s3_step_r;

  logic [dhsd_pkg::LEN_W-1:0] n_len;
  logic [KW-1:0]              key_sum;
  logic [2:0]                 code;
  logic [2*KW-1:0]            prod_pos, prod_step;
  logic [KW-1:0]              rem_pos, rem_step;
  logic [KW-1:0]              fix_pos, fix_step;

  // Backpressure chain through the stages.
  assign ready3      = !s3_valid_r || job_ready;
  assign ready2      = !s2_valid_r || ready3;
  assign ready1      = !s1_valid_r || ready2;
  assign in_ch.ready = ready1;

  // Key: clamp the length, then sum the weighted letter codes.
  always_comb begin
    if (in_ch.length == '0) begin
      n_len = dhsd_pkg::LEN_W'(1);
    end else if (in_ch.length > dhsd_pkg::LEN_W'(dhsd_pkg::MAX_LETTERS)) begin
      n_len = dhsd_pkg::LEN_W'(dhsd_pkg::MAX_LETTERS);
    end else begin
      n_len = in_ch.length;
    end
    key_sum = '0;
    code    = '0;
    for (int k = 0; k < dhsd_pkg::MAX_LETTERS; k++) begin
      code = {1'b0, in_ch.letters[2*k +: 2]} + 3'd1;
      if (dhsd_pkg::LEN_W'(k) < n_len) begin
        key_sum = key_sum + dhsd_pkg::LETTER_WEIGHT[k] * {{(KW-3){1'b0}}, code};
      end
    end
  end

  // Quotient estimates by multiplication with the scaled reciprocals.
  assign prod_pos  = {{KW{1'b0}}, s1_key_r} * {{KW{1'b0}}, dhsd_pkg::RECIP_POS};
  assign prod_step = {{KW{1'b0}}, s1_key_r} * {{KW{1'b0}}, dhsd_pkg::RECIP_STEP};

  // Remainders, with one correction each since the estimate may be one low.
  always_comb begin
    rem_pos  = s2_key_r - s2_qpos_r * dhsd_pkg::MOD_POS;
    rem_step = s2_key_r - s2_qstep_r * dhsd_pkg::MOD_STEP;
    fix_pos  = (rem_pos >= dhsd_pkg::MOD_POS) ? rem_pos - dhsd_pkg::MOD_POS : rem_pos;
    fix_step = (rem_step >= dhsd_pkg::MOD_STEP) ? rem_step - dhsd_pkg::MOD_STEP : rem_step;
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (ready1) s1_valid_r <= in_ch.valid;
      if (ready2) s2_valid_r <= s1_valid_r;
      if (ready3) s3_valid_r <= s2_valid_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (ready1 && in_ch.valid) begin
      s1_op_r  <= in_ch.operation;
      s1_key_r <= key_sum;
    end
    if (ready2 && s1_valid_r) begin
      s2_op_r    <= s1_op_r;
      s2_key_r   <= s1_key_r;
      s2_qpos_r  <= prod_pos[2*KW-1:KW];
      s2_qstep_r <= prod_step[2*KW-1:KW];
    end
    if (ready3 && s2_valid_r) begin
      s3_op_r   <= s2_op_r;
      s3_key_r  <= s2_key_r;
      s3_pos_r  <= fix_pos[SW-1:0];
      s3_step_r <= fix_step[SW-1:0] + SW'(1);
    end
  end

  assign job_valid = s3_valid_r;
  assign job.op    = s3_op_r;
  assign job.key   = s3_key_r;
  assign job.pos   = s3_pos_r;
  assign job.step  = s3_step_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dhsd_queue.sv =====
// Short queue of hashed requests between the front and the back end.
`default_nettype none

module dhsd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dhsd_pkg::job_t  push_job,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output dhsd_pkg::job_t       pop_job,
  output logic                 pop_valid,
  input  wire logic            pop_ready
);

  localparam int AW = dhsd_pkg::QUEUE_AW;

  dhsd_pkg::job_t  entry_r [dhsd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != (AW + 1)'(dhsd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (AW + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dhsd_back.sv =====
// Back end: clears the key table after reset, then probes it for each request.
`default_nettype none

module dhsd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dhsd_pkg::job_t  pop_job,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  dhsd_out_if.source           out_ch
);

  localparam int KW = dhsd_pkg::KEY_W;
  localparam int SW = dhsd_pkg::SLOT_W;
  localparam int CW = dhsd_pkg::CNT_W;

  // Sequencer states.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [KW-1:0] table_mem [dhsd_pkg::TABLE_SIZE];
  logic [KW-1:0] rd_data_r;

  logic [1:0]                      state_r, state_nxt;
  logic [SW-1:0]                   clr_addr_r, clr_addr_nxt;
  logic [dhsd_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [KW-1:0]                   key_r, key_nxt;
  logic [SW-1:0]                   pos_r, pos_nxt;
  logic [SW-1:0]                   step_r, step_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [dhsd_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [dhsd_pkg::SLOT_FIELD_W-1:0] out_slot_r, out_slot_nxt;

  logic          mem_we;
  logic [SW-1:0] mem_waddr, mem_raddr;
  logic [KW-1:0] mem_wdata;
  logic [SW-1:0] next_probe;

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= table_mem[mem_raddr];
  end

  assign pop_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign next_probe = dhsd_pkg::slot_add(pos_r, step_r);

  // Sequencer: clearing pass, dispatch, and one probe check per cycle.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = key_r;
    mem_raddr      = next_probe;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == SW'(dhsd_pkg::TABLE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + SW'(1);
        end
      end
      S_IDLE: begin
        mem_raddr = dhsd_pkg::slot_add(pop_job.pos, pop_job.step);
        if (pop_valid && pop_ready) begin
          op_nxt    = pop_job.op;
          key_nxt   = pop_job.key;
          step_nxt  = pop_job.step;
          pos_nxt   = mem_raddr;
          cnt_nxt   = CW'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // The read of the following slot is issued ahead of the outcome.
        if (rd_data_r == '0) begin
          if (op_r == dhsd_pkg::OP_INSERT) begin
            mem_we         = 1'b1;
            out_status_nxt = dhsd_pkg::ST_INSERTED;
            out_slot_nxt   = dhsd_pkg::to_slot_field(pos_r);
          end else begin
            out_status_nxt = dhsd_pkg::ST_NOT_FOUND;
            out_slot_nxt   = '0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (rd_data_r == key_r) begin
          out_status_nxt = (op_r == dhsd_pkg::OP_FIND) ? dhsd_pkg::ST_FOUND
                                                       : dhsd_pkg::ST_PRESENT;
          out_slot_nxt   = dhsd_pkg::to_slot_field(pos_r);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (cnt_r == CW'(dhsd_pkg::TABLE_SIZE)) begin
          out_status_nxt = dhsd_pkg::ST_FULL;
          out_slot_nxt   = '0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          pos_nxt = next_probe;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;

endmodule

`default_nettype wire

// ===== hw/rtl/double_hash_string_dictionary_unit.sv =====
// Top level of the double-hashing DNA string dictionary.
//
//   Channel  Direction  Handshake      Payload
//   in_ch    sink       valid / ready  operation, letters, length
//   out_ch   source     valid / ready  status, slot
//
// A request passes a three-stage hashing front end and a two-entry queue,
// then a dispatch step and one check per probe of the key table,
// whose single read port limits the back end to one probe per cycle.
// After reset the back end first zeroes every slot of the table;
// requests are still taken until the front end and queue fill up.
// The result register frees the back end as soon as the result is taken.
`default_nettype none

module double_hash_string_dictionary_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  dhsd_in_if.sink      in_ch,
  dhsd_out_if.source   out_ch
);

  dhsd_pkg::job_t push_job, pop_job;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;

  // Key and hash computation.
  dhsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job       (push_job),
    .job_valid (push_valid),
    .job_ready (push_ready)
  );

  // Decoupling queue.
  dhsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_job    (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Table probing and result transaction.
  dhsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_job   (pop_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/dhsd_lookup_checker.sv =====
// Checker that predicts every dictionary lookup and compares it with the result channel.
module dhsd_lookup_checker
  import dhsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dhsd_in_if          req_mon,
  dhsd_out_if         rsp_mon,
  input  logic        end_check,
  output int unsigned fail_count,
  output int unsigned fill_level
);

  localparam int unsigned KEY_BASE = 5;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
  } reply_t;

  // Shadow copy of the key table and the replies still owed by the block.
  logic [KEY_W-1:0] key_table [TABLE_SIZE];
  reply_t           pending_replies [$];
  int unsigned      errors = 0;
  int unsigned      stored_count = 0;
  bit               end_seen = 1'b0;

  assign fail_count = errors;

  // Base-5 key of a string, A=1 .. T=4, first letter in the lowest digit.
  function automatic logic [KEY_W-1:0] string_key(input logic [LETTERS_W-1:0] letters,
                                                  input logic [LEN_W-1:0]     length);
    int unsigned n;
    int unsigned k;
    logic [31:0] acc;
    logic [31:0] weight;
    n = length;
    if (n == 0) n = 1;
    if (n > MAX_LETTERS) n = MAX_LETTERS;
    acc    = 0;
    weight = 1;
    for (k = 0; k < n; k++) begin
      acc    = acc + weight * (32'(letters[2*k +: 2]) + 32'd1);
      weight = weight * KEY_BASE;
    end
    return acc[KEY_W-1:0];
  endfunction

  // Walks the double-hash probe sequence, storing the key on an insert that meets an empty slot.
  function automatic reply_t probe_table(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int unsigned      kv;
    int unsigned      pos;
    int unsigned      stride;
    int unsigned      probe;
    logic [KEY_W-1:0] held;
    reply_t           r;
    kv       = key;
    r.status = ST_FULL;
    r.slot   = '0;
    pos      = kv % TABLE_SIZE;
    stride   = 1 + kv % (TABLE_SIZE - 1);
    for (probe = 1; probe <= TABLE_SIZE; probe++) begin
      pos  = (pos + stride) % TABLE_SIZE;
      held = key_table[pos];
      if (held == '0) begin
        if (op == OP_FIND) begin
          r.status = ST_NOT_FOUND;
        end else begin
          key_table[pos] = key;
          stored_count++;
          r.status = ST_INSERTED;
          r.slot   = SLOT_FIELD_W'(pos);
        end
        break;
      end
      if (held == key) begin
        r.status = (op == OP_FIND) ? ST_FOUND : ST_PRESENT;
        r.slot   = SLOT_FIELD_W'(pos);
        break;
      end
    end
    return r;
  endfunction

  // Counts a failure and reports it.
  task automatic flag_failure(input string what);
    errors++;
    $error("%s", what);
  endtask

  // Predict on every request transaction, compare on every result transaction.
  always @(posedge clk) begin : watch
    reply_t want;
    reply_t got;
    int     idx;
    if (!rst_n) begin
      for (idx = 0; idx < TABLE_SIZE; idx++) key_table[idx] = '0;
      pending_replies.delete();
      stored_count = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        pending_replies.push_back(
          probe_table(req_mon.operation, string_key(req_mon.letters, req_mon.length)));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status = rsp_mon.status;
        got.slot   = rsp_mon.slot;
        if (pending_replies.size() == 0) begin
          flag_failure($sformatf("result with no request outstanding: status %0d, slot %0d",
                                 got.status, got.slot));
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status) begin
            flag_failure($sformatf("status mismatch: expected %0d, actual %0d",
                                   want.status, got.status));
          end
          if (got.slot !== want.slot) begin
            flag_failure($sformatf("slot mismatch: expected %0d, actual %0d",
                                   want.slot, got.slot));
          end
        end
      end
      // Anything still owed at the end of the run is a missing result.
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        foreach (pending_replies[i]) begin
          flag_failure($sformatf("missing result: expected status %0d, slot %0d",
                                 pending_replies[i].status, pending_replies[i].slot));
        end
      end
    end
    fill_level <= stored_count;
  end

endmodule

// ===== bench/double_hash_string_dictionary_unit_test.sv =====
// Top of the dictionary testbench: clock, reset, request and result pacing, and the verdict.
module double_hash_string_dictionary_unit_test;
  import dhsd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 30000;
  localparam int unsigned HOLD_LEN         = 300;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned RANDOM_PER_PHASE = 470;

  typedef struct packed {
    logic [LETTERS_W-1:0] letters;
    logic [LEN_W-1:0]     length;
  } dna_string_t;

  logic        clk;
  logic        rst_n;
  logic        end_check;
  int unsigned fail_count;
  int unsigned fill_level;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asks;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned req_count;
  int unsigned reply_count;
  int unsigned idle_cycles;
  dna_string_t used_strings [$];

  dhsd_in_if  in_bus ();
  dhsd_out_if out_bus ();

  double_hash_string_dictionary_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  dhsd_lookup_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_bus),
    .rsp_mon    (out_bus),
    .end_check  (end_check),
    .fail_count (fail_count),
    .fill_level (fill_level)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, or a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_served   <= 0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      out_bus.ready <= 1'b0;
      hold_served   <= hold_asks;
      hold_left     <= HOLD_LEN;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Transaction counters on both channels.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_count   <= 0;
      reply_count <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) req_count <= req_count + 1;
      if (out_bus.valid && out_bus.ready) reply_count <= reply_count + 1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned used_letters(input logic [LEN_W-1:0] length);
    if (length == 0) return 1;
    if (length > MAX_LETTERS) return MAX_LETTERS;
    return length;
  endfunction

  // Offers one request after a random gap and returns at the edge that accepts it.
  task automatic send_request(input logic [OP_W-1:0]      op,
                              input logic [LETTERS_W-1:0] letters,
                              input logic [LEN_W-1:0]     length);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.letters   <= letters;
    in_bus.length    <= length;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Random request: often a string seen before, so that inserts and finds meet stored keys.
  task automatic random_request();
    logic [OP_W-1:0]      op;
    logic [LETTERS_W-1:0] letters;
    logic [LETTERS_W-1:0] spare_mask;
    logic [LEN_W-1:0]     length;
    dna_string_t          s;
    int unsigned          n;
    int unsigned          pick;
    op = $urandom_range(1) ? OP_FIND : OP_INSERT;
    if (used_strings.size() != 0 && $urandom_range(99) < 45) begin
      // Same string, with the bits beyond its length scrambled.
      s          = used_strings[$urandom_range(used_strings.size() - 1)];
      n          = used_letters(s.length);
      spare_mask = {LETTERS_W{1'b1}} << (2 * n);
      letters    = (s.letters & ~spare_mask) | (LETTERS_W'($urandom) & spare_mask);
      length     = s.length;
    end else begin
      letters = LETTERS_W'($urandom);
      pick    = $urandom_range(99);
      if (pick < 4) length = '0;
      else if (pick < 10) length = LEN_W'($urandom_range(15, MAX_LETTERS + 1));
      else length = LEN_W'($urandom_range(MAX_LETTERS, 1));
      s.letters = letters;
      s.length  = length;
      used_strings.push_back(s);
    end
    send_request(op, letters, length);
  endtask

  // Stops offering and waits until every request has its result.
  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (reply_count != req_count) @(posedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n            = 1'b0;
    end_check        = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_INSERT;
    in_bus.letters   = '0;
    in_bus.length    = '0;
    hold_asks        = 0;
    send_idle_pct    = 21;
    recv_idle_pct    = 74;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests, the first of them taken while the table is still being cleared.
    send_request(OP_INSERT, 24'h000000, 4'd1);
    send_request(OP_INSERT, 24'hFFFFFF, 4'd12);
    send_request(OP_INSERT, 24'hFFFFFF, 4'd12);
    send_request(OP_FIND,   24'h000000, 4'd1);
    send_request(OP_FIND,   24'hFFFFFF, 4'd12);
    send_request(OP_FIND,   24'h555555, 4'd12);
    // Length zero counts as one letter.
    send_request(OP_INSERT, 24'hABCDE2, 4'd0);
    send_request(OP_FIND,   24'h000002, 4'd1);
    // Lengths above twelve count as twelve.
    send_request(OP_INSERT, 24'h123456, 4'd15);
    send_request(OP_FIND,   24'h123456, 4'd12);
    send_request(OP_FIND,   24'h123456, 4'd13);
    send_request(OP_INSERT, 24'h000001, 4'd14);
    // Letters past the length do not matter.
    send_request(OP_INSERT, 24'hFFFFF1, 4'd1);
    send_request(OP_FIND,   24'h000001, 4'd1);
    send_request(OP_FIND,   24'hAAAAAA, 4'd7);
    send_request(OP_INSERT, 24'hAAAAAA, 4'd7);
    send_request(OP_FIND,   24'h2AAAAA, 4'd7);
    send_request(OP_INSERT, 24'h555555, 4'd12);
    send_request(OP_FIND,   24'h555555, 4'd12);

    // Slow receiver.
    repeat (RANDOM_PER_PHASE) random_request();
    wait_for_drain();

    // Slow sender.
    send_idle_pct  = 74;
    recv_idle_pct <= 21;
    repeat (RANDOM_PER_PHASE) random_request();
    wait_for_drain();

    // No idling, with one long result stall while requests keep coming.
    send_idle_pct  = 0;
    recv_idle_pct <= 0;
    repeat (RANDOM_PER_PHASE / 2) random_request();
    hold_asks <= hold_asks + 1;
    repeat (RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2) random_request();
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Checked %0d requests and %0d results under three pacing mixes and a long stall,",
             req_count, reply_count);
    $display("with %0d of the %0d slots holding keys at the end.", fill_level, TABLE_SIZE);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
